@@ rtl/hpc_pkg.sv @@
// Shared types and constants for the hodgepodge cell update pipeline.
// Depends on nothing; every other file in rtl imports it.
package hpc_pkg;

    // Width of one configuration value and of a limited cell state.
    localparam int CFG_W = 8;
    // Width of the two neighbour-count divisors.
    localparam int DIV_W = 4;
    // Width of the configuration register index.
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NUM_STATES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTER_DIV  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_DIV    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED      = 2'd3;

    // Limits applied to the configuration values.
    localparam logic [CFG_W-1:0] STATES_MIN  = 8'd2;
    localparam logic [DIV_W-1:0] DIVISOR_MIN = 4'd1;
    localparam logic [DIV_W-1:0] DIVISOR_MAX = 4'd8;
    localparam logic [CFG_W-1:0] SPEED_MIN   = 8'd1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] RST_NUM_STATES = 8'd100;
    localparam logic [DIV_W-1:0] RST_INTER_DIV  = 4'd2;
    localparam logic [DIV_W-1:0] RST_SAT_DIV    = 4'd3;
    localparam logic [CFG_W-1:0] RST_SPEED      = 8'd1;

    // How the center cell is updated.
    localparam logic [1:0] MODE_ACTIVE = 2'd0;
    localparam logic [1:0] MODE_IDLE   = 2'd1;
    localparam logic [1:0] MODE_SAT    = 2'd2;

    // Divider lanes: the neighbourhood average and the two count quotients.
    localparam int NUM_LANES = 3;
    localparam int LANE_AVG  = 0;
    localparam int LANE_INT  = 1;
    localparam int LANE_SAT  = 2;

    // Configuration after clamping.
    typedef struct packed {
        logic [CFG_W-1:0] n;
        logic [DIV_W-1:0] k1;
        logic [DIV_W-1:0] k2;
        logic [CFG_W-1:0] spd;
    } t_cfg;

    // Per-item control that rides along the divider.
    typedef struct packed {
        logic [1:0]       mode;
        logic [CFG_W-1:0] n;
        logic [CFG_W-1:0] spd;
    } t_side;

endpackage

@@ rtl/hodgepodge_cell_update_top.sv @@
// Hodgepodge cell update: requests pass through classification, a pipelined divider
// and the finish stage; one request is taken every cycle unless the output stalls.
// The divider resolves one quotient bit per stage.
// Reset (synchronous, active low) empties every pipeline stage and loads the
// configuration registers with N = 100, k1 = 2, k2 = 3 and speed = 1.
// Depends on hpc_pkg, hpc_classify, hpc_div_pipe and hpc_finish.
module hodgepodge_cell_update_top #(
    parameter int NEIGHBORS = 6,
    parameter int STATE_BITS = 8,
    localparam int IN_W = (NEIGHBORS + 1) * STATE_BITS,
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((STATE_BITS + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input cell requests.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata from bit 0 up: center_state, neighbor_0 .. neighbor_(NEIGHBORS-1),
    // zero padding to a whole byte.
    input  logic [IN_TDATA_W-1:0]             s_axis_tdata,
    // tuser: neighbor_valid, bit i for neighbour i.
    input  logic [NEIGHBORS-1:0]              s_axis_tuser,
    // Result requests.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata from bit 0 up: next_state, zero padding to a whole byte.
    output logic [OUT_TDATA_W-1:0]            m_axis_tdata,
    // Configuration writes.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hpc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hpc_pkg::CFG_W-1:0]         i_cfg_data
);
    import hpc_pkg::*;

    localparam int VW = (STATE_BITS > CFG_W) ? STATE_BITS : CFG_W;
    localparam int SW = CFG_W + $clog2(NEIGHBORS + 1);
    localparam int CW = $clog2(NEIGHBORS + 2);
    localparam int DW = (CW > DIV_W) ? CW : DIV_W;

    // Configuration registers, written as the host sends them. Clamping to
    // the legal ranges happens on the way into the pipeline.
    logic [CFG_W-1:0] r_num_states;
    logic [DIV_W-1:0] r_inter_div;
    logic [DIV_W-1:0] r_sat_div;
    logic [CFG_W-1:0] r_speed;

    t_cfg             w_cfg;
    logic [CFG_W-1:0] w_n_minus1;

    logic             w_cls_valid;
    logic             w_cls_ready;
    logic [SW-1:0]    w_cls_num [NUM_LANES];
    logic [DW-1:0]    w_cls_den [NUM_LANES];
    t_side            w_cls_side;

    logic             w_div_valid;
    logic             w_div_ready;
    logic [SW-1:0]    w_div_quo [NUM_LANES];
    t_side            w_div_side;

    logic [CFG_W-1:0] w_result;
    logic [VW-1:0]    w_result_ext;

    // The port never stalls; the host must see that writes arrive only while idle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_states <= RST_NUM_STATES;
            r_inter_div  <= RST_INTER_DIV;
            r_sat_div    <= RST_SAT_DIV;
            r_speed      <= RST_SPEED;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_NUM_STATES: r_num_states <= i_cfg_data;
                REG_INTER_DIV:  r_inter_div  <= i_cfg_data[DIV_W-1:0];
                REG_SAT_DIV:    r_sat_div    <= i_cfg_data[DIV_W-1:0];
                REG_SPEED:      r_speed      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // N is at least 2, both divisors lie in 1..8 and speed in 1..N-1.
    always_comb begin
        w_cfg.n = (r_num_states < STATES_MIN) ? STATES_MIN : r_num_states;
        if (r_inter_div < DIVISOR_MIN) begin
            w_cfg.k1 = DIVISOR_MIN;
        end else if (r_inter_div > DIVISOR_MAX) begin
            w_cfg.k1 = DIVISOR_MAX;
        end else begin
            w_cfg.k1 = r_inter_div;
        end
        if (r_sat_div < DIVISOR_MIN) begin
            w_cfg.k2 = DIVISOR_MIN;
        end else if (r_sat_div > DIVISOR_MAX) begin
            w_cfg.k2 = DIVISOR_MAX;
        end else begin
            w_cfg.k2 = r_sat_div;
        end
        w_n_minus1 = w_cfg.n - CFG_W'(1);
        if (r_speed < SPEED_MIN) begin
            w_cfg.spd = SPEED_MIN;
        end else if (r_speed > w_n_minus1) begin
            w_cfg.spd = w_n_minus1;
        end else begin
            w_cfg.spd = r_speed;
        end
    end

    // Two stages: state limiting and classification, then sum and counts.
    hpc_classify #(
        .NEIGHBORS  (NEIGHBORS),
        .STATE_BITS (STATE_BITS)
    ) u_classify (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_center    (s_axis_tdata[STATE_BITS-1:0]),
        .i_neighbors (s_axis_tdata[IN_W-1:STATE_BITS]),
        .i_nvalid    (s_axis_tuser),
        .i_cfg       (w_cfg),
        .o_valid     (w_cls_valid),
        .i_ready     (w_cls_ready),
        .o_num       (w_cls_num),
        .o_den       (w_cls_den),
        .o_side      (w_cls_side)
    );

    // The average and both count quotients are divided side by side, so every
    // request passes through the same divider stages whatever its mode.
    hpc_div_pipe #(
        .NW (SW),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cls_valid),
        .o_ready (w_cls_ready),
        .i_num   (w_cls_num),
        .i_den   (w_cls_den),
        .i_side  (w_cls_side),
        .o_valid (w_div_valid),
        .i_ready (w_div_ready),
        .o_quo   (w_div_quo),
        .o_side  (w_div_side)
    );

    // Rule selection and the output register.
    hpc_finish #(
        .NW (SW)
    ) u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_valid),
        .o_ready (w_div_ready),
        .i_quo   (w_div_quo),
        .i_side  (w_div_side),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_state (w_result)
    );

    // The result never exceeds N, so it fits in any state width that can hold
    // the configured N.
    assign w_result_ext = VW'(w_result);
    assign m_axis_tdata = OUT_TDATA_W'(w_result_ext[STATE_BITS-1:0]);

    // With the output register empty every stage can move, so input is open.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while the output register is empty");

    a_result_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_result <= w_cfg.n))
        else $error("result above the saturated state");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_speed_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && (i_cfg_index == REG_SPEED))
        |=> (r_speed == $past(i_cfg_data)))
        else $error("speed register did not take the written value");

endmodule

@@ rtl/hpc_classify.sv @@
// Front end of the pipeline: limits states, counts neighbours and forms the sum.
// Two register stages. Depends on hpc_pkg.
module hpc_classify #(
    parameter int NEIGHBORS = 6,
    parameter int STATE_BITS = 8,
    localparam int VW = (STATE_BITS > hpc_pkg::CFG_W) ? STATE_BITS : hpc_pkg::CFG_W,
    localparam int SW = hpc_pkg::CFG_W + $clog2(NEIGHBORS + 1),
    localparam int CW = $clog2(NEIGHBORS + 2),
    localparam int DW = (CW > hpc_pkg::DIV_W) ? CW : hpc_pkg::DIV_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [STATE_BITS-1:0]           i_center,
    input  logic [NEIGHBORS*STATE_BITS-1:0] i_neighbors,
    input  logic [NEIGHBORS-1:0]            i_nvalid,
    input  hpc_pkg::t_cfg                   i_cfg,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [SW-1:0]                   o_num [hpc_pkg::NUM_LANES],
    output logic [DW-1:0]                   o_den [hpc_pkg::NUM_LANES],
    output hpc_pkg::t_side                  o_side
);
    import hpc_pkg::*;

    function automatic logic [CFG_W-1:0] f_limit(input logic [STATE_BITS-1:0] raw,
                                                 input logic [CFG_W-1:0] n);
        logic [VW-1:0] ext;
        logic [VW-1:0] nx;
        logic [VW-1:0] lim;
        ext = VW'(raw);
        nx  = VW'(n);
        lim = (ext > nx) ? nx : ext;
        return lim[CFG_W-1:0];
    endfunction

    // Stage A: limited states and per-neighbour class flags.
    logic                 r_a_v;
    logic [CFG_W-1:0]     r_a_center;
    logic [CFG_W-1:0]     r_a_lim [NEIGHBORS];
    logic [NEIGHBORS-1:0] r_a_sat;
    logic [NEIGHBORS-1:0] r_a_int;
    t_cfg                 r_a_cfg;
    logic [CFG_W-1:0]     n_a_center;
    logic [CFG_W-1:0]     n_a_lim [NEIGHBORS];
    logic [NEIGHBORS-1:0] n_a_sat;
    logic [NEIGHBORS-1:0] n_a_int;
    logic                 w_a_ready;

    // Stage B: sum, counts and divider operands.
    logic             r_b_v;
    logic [SW-1:0]    r_b_sum;
    logic [CW-1:0]    r_b_cnt1;
    logic [CW-1:0]    r_b_inter;
    logic [CW-1:0]    r_b_satc;
    logic [DIV_W-1:0] r_b_k1;
    logic [DIV_W-1:0] r_b_k2;
    t_side            r_b_side;
    logic [SW-1:0]    n_b_sum;
    logic [CW-1:0]    n_b_inter;
    logic [CW-1:0]    n_b_satc;
    logic [CW-1:0]    n_b_cnt1;
    t_side            n_b_side;
    logic             w_b_ready;

    assign w_b_ready = !r_b_v || i_ready;
    assign w_a_ready = !r_a_v || w_b_ready;
    assign o_ready   = w_a_ready;

    always_comb begin
        logic [CFG_W-1:0] s;
        n_a_center = f_limit(i_center, i_cfg.n);
        for (int i = 0; i < NEIGHBORS; i++) begin
            s = f_limit(i_neighbors[i*STATE_BITS +: STATE_BITS], i_cfg.n);
            if (i_nvalid[i]) begin
                n_a_lim[i] = s;
                n_a_sat[i] = (s == i_cfg.n);
                n_a_int[i] = (s != '0) && (s != i_cfg.n);
            end else begin
                n_a_lim[i] = '0;
                n_a_sat[i] = 1'b0;
                n_a_int[i] = 1'b0;
            end
        end
    end

    always_comb begin
        n_b_sum   = SW'(r_a_center);
        n_b_inter = '0;
        n_b_satc  = '0;
        for (int i = 0; i < NEIGHBORS; i++) begin
            n_b_sum   = n_b_sum + SW'(r_a_lim[i]);
            n_b_inter = n_b_inter + CW'(r_a_int[i]);
            n_b_satc  = n_b_satc + CW'(r_a_sat[i]);
        end
        n_b_cnt1 = n_b_inter + n_b_satc + CW'(1);
        if (r_a_center == r_a_cfg.n) begin
            n_b_side.mode = MODE_SAT;
        end else if (r_a_center == '0) begin
            n_b_side.mode = MODE_IDLE;
        end else begin
            n_b_side.mode = MODE_ACTIVE;
        end
        n_b_side.n   = r_a_cfg.n;
        n_b_side.spd = r_a_cfg.spd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (w_a_ready) begin
                r_a_v <= i_valid;
            end
            if (w_b_ready) begin
                r_b_v <= r_a_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready && i_valid) begin
            r_a_center <= n_a_center;
            r_a_lim    <= n_a_lim;
            r_a_sat    <= n_a_sat;
            r_a_int    <= n_a_int;
            r_a_cfg    <= i_cfg;
        end
        if (w_b_ready && r_a_v) begin
            r_b_sum   <= n_b_sum;
            r_b_cnt1  <= n_b_cnt1;
            r_b_inter <= n_b_inter;
            r_b_satc  <= n_b_satc;
            r_b_k1    <= r_a_cfg.k1;
            r_b_k2    <= r_a_cfg.k2;
            r_b_side  <= n_b_side;
        end
    end

    assign o_valid           = r_b_v;
    assign o_side            = r_b_side;
    assign o_num[LANE_AVG]   = r_b_sum;
    assign o_den[LANE_AVG]   = DW'(r_b_cnt1);
    assign o_num[LANE_INT]   = SW'(r_b_inter);
    assign o_den[LANE_INT]   = DW'(r_b_k1);
    assign o_num[LANE_SAT]   = SW'(r_b_satc);
    assign o_den[LANE_SAT]   = DW'(r_b_k2);

endmodule

@@ rtl/hpc_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, three lanes side by side.
// Carries a control word alongside. Depends on hpc_pkg.
module hpc_div_pipe #(
    parameter int NW = 11,
    parameter int DW = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [NW-1:0]  i_num [hpc_pkg::NUM_LANES],
    input  logic [DW-1:0]  i_den [hpc_pkg::NUM_LANES],
    input  hpc_pkg::t_side i_side,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [NW-1:0]  o_quo [hpc_pkg::NUM_LANES],
    output hpc_pkg::t_side o_side
);
    import hpc_pkg::*;

    // Each stage holds the not yet consumed numerator bits in the upper part of
    // r_nq and the quotient bits found so far in the lower part.
    logic          r_v    [NW];
    logic [NW-1:0] r_nq   [NW][NUM_LANES];
    logic [DW-1:0] r_rem  [NW][NUM_LANES];
    logic [DW-1:0] r_den  [NW][NUM_LANES];
    t_side         r_side [NW];

    logic          w_v_in    [NW];
    logic [NW-1:0] w_nq_in   [NW][NUM_LANES];
    logic [DW-1:0] w_rem_in  [NW][NUM_LANES];
    logic [DW-1:0] w_den_in  [NW][NUM_LANES];
    t_side         w_side_in [NW];
    logic [NW-1:0] n_nq      [NW][NUM_LANES];
    logic [DW-1:0] n_rem     [NW][NUM_LANES];
    logic          w_rdy     [NW+1];

    assign w_rdy[NW] = i_ready;

    for (genvar k = 0; k < NW; k++) begin : g_stage
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];

        if (k == 0) begin : g_first
            assign w_v_in[k]    = i_valid;
            assign w_side_in[k] = i_side;
            for (genvar l = 0; l < NUM_LANES; l++) begin : g_src
                assign w_nq_in[k][l]  = i_num[l];
                assign w_rem_in[k][l] = '0;
                assign w_den_in[k][l] = i_den[l];
            end
        end else begin : g_next
            assign w_v_in[k]    = r_v[k-1];
            assign w_side_in[k] = r_side[k-1];
            for (genvar l = 0; l < NUM_LANES; l++) begin : g_src
                assign w_nq_in[k][l]  = r_nq[k-1][l];
                assign w_rem_in[k][l] = r_rem[k-1][l];
                assign w_den_in[k][l] = r_den[k-1][l];
            end
        end

        for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
            always_comb begin
                logic [DW:0] sh;
                logic [DW:0] diff;
                sh   = {w_rem_in[k][l], w_nq_in[k][l][NW-1]};
                diff = sh - {1'b0, w_den_in[k][l]};
                if (sh >= {1'b0, w_den_in[k][l]}) begin
                    n_rem[k][l] = diff[DW-1:0];
                    n_nq[k][l]  = {w_nq_in[k][l][NW-2:0], 1'b1};
                end else begin
                    n_rem[k][l] = sh[DW-1:0];
                    n_nq[k][l]  = {w_nq_in[k][l][NW-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[k] && w_v_in[k]) begin
                    r_nq[k][l]  <= n_nq[k][l];
                    r_rem[k][l] <= n_rem[k][l];
                    r_den[k][l] <= w_den_in[k][l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= w_v_in[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k] && w_v_in[k]) begin
                r_side[k] <= w_side_in[k];
            end
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_out
        assign o_quo[l] = r_nq[NW-1][l];
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

@@ rtl/hpc_finish.sv @@
// Last stage: picks the update rule per mode and holds the result register.
// Depends on hpc_pkg.
module hpc_finish #(
    parameter int NW = 11
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [NW-1:0]            i_quo [hpc_pkg::NUM_LANES],
    input  hpc_pkg::t_side           i_side,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [hpc_pkg::CFG_W-1:0] o_state
);
    import hpc_pkg::*;

    logic             r_v;
    logic [CFG_W-1:0] r_state;
    logic [CFG_W-1:0] n_state;
    logic             w_ready;

    assign w_ready = !r_v || i_ready;
    assign o_ready = w_ready;

    always_comb begin
        logic [NW:0] idle_sum;
        logic [NW:0] act_sum;
        logic [NW:0] modulus;
        logic [NW:0] wrapped;
        idle_sum = {1'b0, i_quo[LANE_INT]} + {1'b0, i_quo[LANE_SAT]};
        act_sum  = {1'b0, i_quo[LANE_AVG]} + (NW+1)'(i_side.spd);
        modulus  = (NW+1)'(i_side.n) + (NW+1)'(1);
        wrapped  = act_sum - modulus;
        case (i_side.mode)
            MODE_SAT: begin
                n_state = '0;
            end
            MODE_IDLE: begin
                if (idle_sum > (NW+1)'(i_side.n)) begin
                    n_state = i_side.n;
                end else begin
                    n_state = idle_sum[CFG_W-1:0];
                end
            end
            MODE_ACTIVE: begin
                // The average never exceeds N and speed stays below N, so one
                // subtraction brings the sum back into range.
                if (act_sum >= modulus) begin
                    n_state = wrapped[CFG_W-1:0];
                end else begin
                    n_state = act_sum[CFG_W-1:0];
                end
            end
            default: begin
                n_state = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_v;
    assign o_state = r_state;

endmodule
